// ===== hdl/mbrm_pkg.sv =====
// Package for the two-bank RAM mapper: size codes, register indexes,
// request bit positions, configuration and mapping result types.
// No dependencies.
`default_nettype none

package mbrm_pkg;

    // Word store geometry.
    localparam int RAM_WORDS = 2097152;
    localparam int IDX_W     = $clog2(RAM_WORDS);

    // Field and internal widths.
    localparam int ADDR_W  = 24;
    localparam int DATA_W  = 16;
    localparam int TYPE_W  = 2;
    localparam int SIZE_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int OFS_W   = 21;   // offset inside one bank, below 2MB
    localparam int PHYS_W  = 22;   // physical byte address, below 4MB

    // Request type bits: bit 0 selects a word, bit 1 a write.
    localparam int REQ_WORD_BIT  = 0;
    localparam int REQ_WRITE_BIT = 1;

    // Bank size codes.
    localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_128K = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_512K = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_2M   = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_BANK0_SIZE  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BANK1_SIZE  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_REAL0_SIZE  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_REAL1_SIZE  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MODEL_STE   = 3'd4;

    // Addresses above this limit raise a bus error.
    localparam logic [ADDR_W-1:0] LIMIT_4MB = 24'h400000;

    // Byte and word fill values for unmapped reads.
    localparam logic [DATA_W-1:0] ONES_BYTE = 16'h00FF;
    localparam logic [DATA_W-1:0] ONES_WORD = 16'hFFFF;

    typedef struct packed {
        logic [SIZE_W-1:0] cfg_bank0_size;
        logic [SIZE_W-1:0] cfg_bank1_size;
        logic [SIZE_W-1:0] real_bank0_size;
        logic [SIZE_W-1:0] real_bank1_size;
        logic              model_is_ste;
    } t_cfg;

    typedef struct packed {
        logic              bus_error;
        logic              in_gap;
        logic              ok;        // inside fitted RAM and the store
        logic [PHYS_W-1:0] phys;
    } t_map_res;

    // Size of a bank in bytes for a size code.
    function automatic logic [PHYS_W-1:0] size_bytes(input logic [SIZE_W-1:0] code);
        logic [PHYS_W-1:0] bytes;
        unique case (code)
            SIZE_128K: bytes = 22'h020000;
            SIZE_512K: bytes = 22'h080000;
            SIZE_2M:   bytes = 22'h200000;
            default:   bytes = '0;
        endcase
        return bytes;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrm_req_if.sv =====
// Request channel interface for the two-bank RAM mapper.
// Depends on mbrm_pkg for the field widths.
`default_nettype none

interface mbrm_req_if;
    import mbrm_pkg::*;

    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/mbrm_rsp_if.sv =====
// Response channel interface for the two-bank RAM mapper.
// Depends on mbrm_pkg for the field widths.
`default_nettype none

interface mbrm_rsp_if;
    import mbrm_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_data;
    logic                bus_error;
    logic                in_gap;

    modport source (output valid, output read_data, output bus_error, output in_gap,
                    input ready);
    modport sink   (input valid, input read_data, input bus_error, input in_gap,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/mbrm_map.sv =====
// Address mapper: splits a bus address into banks, clears the row and column
// lines the fitted chips lack and relocates bank 1. Depends on mbrm_pkg.
`default_nettype none

module mbrm_map (
    input  mbrm_pkg::t_cfg              i_cfg,
    input  logic [mbrm_pkg::ADDR_W-1:0] i_address,
    input  logic                        i_is_word,
    output mbrm_pkg::t_map_res          o_map
);
    import mbrm_pkg::*;

    logic [PHYS_W-1:0] w_cfg0, w_cfg1, w_real0, w_real1;
    logic [PHYS_W:0]   w_total;
    logic [ADDR_W-1:0] w_ad, w_rel;
    logic              w_second, w_berr, w_gap;
    logic [SIZE_W-1:0] w_cfg_code, w_real_code;
    logic [OFS_W-1:0]  w_clr, w_ofs;
    logic [PHYS_W-1:0] w_phys;
    logic [PHYS_W:0]   w_end;
    logic              w_in_store;

    // Bank sizes in bytes and the fitted total.
    always_comb begin
        w_cfg0  = size_bytes(i_cfg.cfg_bank0_size);
        w_cfg1  = size_bytes(i_cfg.cfg_bank1_size);
        w_real0 = size_bytes(i_cfg.real_bank0_size);
        w_real1 = size_bytes(i_cfg.real_bank1_size);
        w_total = {1'b0, w_real0} + {1'b0, w_real1};
    end

    // Bank selection, bus error and gap detection.
    always_comb begin
        w_ad = i_address;
        if (i_is_word) begin
            w_ad[0] = 1'b0;
        end
        w_berr   = w_ad > LIMIT_4MB;
        w_second = w_ad >= ADDR_W'(w_cfg0);
        w_rel    = w_second ? (w_ad - ADDR_W'(w_cfg0)) : w_ad;
        w_cfg_code  = w_second ? i_cfg.cfg_bank1_size  : i_cfg.cfg_bank0_size;
        w_real_code = w_second ? i_cfg.real_bank1_size : i_cfg.real_bank0_size;
        w_gap = !w_berr && ((w_second && (w_rel >= ADDR_W'(w_cfg1)))
                            || (w_real_code == SIZE_NONE));
    end

    // Lines missing on smaller chips, by configured and fitted size.
    always_comb begin
        w_clr = '0;
        if (w_cfg_code == SIZE_2M) begin
            if (w_real_code == SIZE_512K) begin
                w_clr = i_cfg.model_is_ste ? 21'h180000 : 21'h100400;
            end else if (w_real_code == SIZE_128K) begin
                w_clr = i_cfg.model_is_ste ? 21'h1E0000 : 21'h180600;
            end
        end else if (w_cfg_code == SIZE_512K) begin
            if (w_real_code == SIZE_128K) begin
                w_clr = i_cfg.model_is_ste ? 21'h060000 : 21'h040200;
            end
        end
    end

    // Physical address and the fitted-RAM range check.
    always_comb begin
        w_ofs  = w_rel[OFS_W-1:0] & ~w_clr;
        w_phys = {1'b0, w_ofs} + (w_second ? w_real0 : '0);
        w_end  = {1'b0, w_phys} + (i_is_word ? (PHYS_W+1)'(2) : (PHYS_W+1)'(1));
        w_in_store = {1'b0, w_phys[PHYS_W-1:1]} < PHYS_W'(RAM_WORDS);
        o_map.bus_error = w_berr;
        o_map.in_gap    = w_gap;
        o_map.ok        = !w_berr && !w_gap && (w_end <= w_total) && w_in_store;
        o_map.phys      = w_phys;
    end

endmodule

`default_nettype wire

// ===== hdl/mismatched_bank_ram_mapper_unit.sv =====
// An accepted request passes through the map, read and write-back states, and its
// result is loaded into the output register as write-back ends. Each access is a
// read-modify-write of the single-port word store, one access at a time.
// A pending result lets the next request be accepted but holds it in write-back until taken.
// Reset is synchronous: control state and configuration return to their defaults;
// the word store is not cleared and holds undefined data until written.
`default_nettype none

module mismatched_bank_ram_mapper_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mbrm_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [mbrm_pkg::SIZE_W-1:0] i_cfg_wdata,
    mbrm_req_if.sink                    i_req,
    mbrm_rsp_if.source                  o_rsp
);
    import mbrm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MAP, S_READ, S_WB} t_state;

    t_state             r_state;
    t_cfg               r_cfg;
    logic [TYPE_W-1:0]  r_type;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_wdata;
    t_map_res           r_map;
    t_map_res           w_map;
    logic [DATA_W-1:0]  r_rdata;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_berr;
    logic               r_out_gap;
    logic [DATA_W-1:0]  r_mem [RAM_WORDS];

    logic               w_accept, w_load, w_is_word, w_is_write, w_mem_we;
    logic [IDX_W-1:0]   w_idx;
    logic [DATA_W-1:0]  w_wr_word, w_rd_val;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cfg_bank0_size  <= SIZE_512K;
            r_cfg.cfg_bank1_size  <= SIZE_512K;
            r_cfg.real_bank0_size <= SIZE_512K;
            r_cfg.real_bank1_size <= SIZE_512K;
            r_cfg.model_is_ste    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BANK0_SIZE: r_cfg.cfg_bank0_size  <= i_cfg_wdata;
                CFG_BANK1_SIZE: r_cfg.cfg_bank1_size  <= i_cfg_wdata;
                CFG_REAL0_SIZE: r_cfg.real_bank0_size <= i_cfg_wdata;
                CFG_REAL1_SIZE: r_cfg.real_bank1_size <= i_cfg_wdata;
                CFG_MODEL_STE:  r_cfg.model_is_ste    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Address mapping of the held request.
    mbrm_map u_map (
        .i_cfg     (r_cfg),
        .i_address (r_addr),
        .i_is_word (w_is_word),
        .o_map     (w_map)
    );

    // Handshakes and request decode.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_WB) && (!r_out_valid || o_rsp.ready);
    assign w_is_word   = r_type[REQ_WORD_BIT];
    assign w_is_write  = r_type[REQ_WRITE_BIT];
    assign w_idx       = r_map.phys[IDX_W:1];
    assign w_mem_we    = w_load && w_is_write && r_map.ok;

    // Merge the new data into the word read back from the store.
    always_comb begin
        if (w_is_word) begin
            w_wr_word = r_wdata;
        end else if (r_map.phys[0]) begin
            w_wr_word = {r_rdata[15:8], r_wdata[7:0]};
        end else begin
            w_wr_word = {r_wdata[7:0], r_rdata[7:0]};
        end
    end

    // Read result; big-endian, so the even byte is the high half.
    always_comb begin
        if (w_is_write || r_map.bus_error) begin
            w_rd_val = '0;
        end else if (r_map.in_gap || !r_map.ok) begin
            w_rd_val = w_is_word ? ONES_WORD : ONES_BYTE;
        end else if (w_is_word) begin
            w_rd_val = r_rdata;
        end else if (r_map.phys[0]) begin
            w_rd_val = {8'h00, r_rdata[7:0]};
        end else begin
            w_rd_val = {8'h00, r_rdata[15:8]};
        end
    end

    // Word store: one read in the read state, one write-back in the last state.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_idx] <= w_wr_word;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    // Sequencer with the request holding registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_type  <= i_req.req_type;
                        r_addr  <= i_req.address;
                        r_wdata <= i_req.write_data;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_map   <= w_map;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_rd_val;
                r_out_berr  <= r_map.bus_error;
                r_out_gap   <= r_map.in_gap;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.bus_error = r_out_berr;
    assign o_rsp.in_gap    = r_out_gap;

    // A store write only happens for an access that maps into fitted RAM.
    a_write_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_map.ok && !r_map.bus_error && !r_map.in_gap))
        else $error("store written for an unmapped access");

    // An accepted request always moves on to mapping.
    a_accept_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MAP))
        else $error("accepted request did not enter mapping");

    // Bus error and gap exclude each other in a result.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.bus_error && o_rsp.in_gap))
        else $error("bus error and gap flagged together");

    // A bus error reads as zero.
    a_berr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bus_error) |-> (o_rsp.read_data == '0))
        else $error("bus error returned non-zero data");

    // The output register is never overwritten while it still holds a result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_out_valid && !o_rsp.ready) |=> (r_state == S_WB))
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire

// ===== sim/mismatched_bank_ram_mapper_unit_test.sv =====
// Self-checking testbench for the two-bank RAM mapper: a directed table, then random
// bus transactions under several bank setups, checked against a behavioural predictor.
// Depends on mbrm_pkg, mbrm_req_if, mbrm_rsp_if and mismatched_bank_ram_mapper_unit.
`default_nettype none

module mismatched_bank_ram_mapper_unit_test;
    import mbrm_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 12;
    localparam int RANDOM_PER_SETUP = 214;
    localparam int NUM_SETUPS       = 9;
    localparam int NUM_ROWS         = 31;
    localparam int POOL_DEPTH       = 256;

    // Index 7 decodes to no register; it also fills the index column of access rows.
    localparam logic [CIDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [CIDX_W-1:0] NO_REG           = CFG_UNUSED_INDEX;

    // Bank sizes in bytes and the row/column lines cleared for each size pair.
    localparam int unsigned BYTES_128K        = 32'h0002_0000;
    localparam int unsigned BYTES_512K        = 32'h0008_0000;
    localparam int unsigned BYTES_2M          = 32'h0020_0000;
    localparam int unsigned CLR_2M_512K_STE   = 32'h0018_0000;
    localparam int unsigned CLR_2M_512K_STF   = 32'h0010_0400;
    localparam int unsigned CLR_2M_128K_STE   = 32'h001E_0000;
    localparam int unsigned CLR_2M_128K_STF   = 32'h0018_0600;
    localparam int unsigned CLR_512K_128K_STE = 32'h0006_0000;
    localparam int unsigned CLR_512K_128K_STF = 32'h0004_0200;

    // Address lines that the decoders may clear; flipping one aims at an alias.
    localparam int ALIAS_BITS [6] = '{9, 10, 17, 18, 19, 20};

    typedef enum logic [TYPE_W-1:0] {
        REQ_BYTE_READ  = 2'd0,
        REQ_WORD_READ  = 2'd1,
        REQ_BYTE_WRITE = 2'd2,
        REQ_WORD_WRITE = 2'd3
    } req_kind_e;

    typedef enum {MAP_RAM, MAP_BUS_ERROR, MAP_GAP} map_kind_e;
    typedef enum {ROW_ACC, ROW_CFG} row_op_e;
    typedef enum {MODEL, TYPED} check_e;

    typedef struct packed {
        req_kind_e           kind;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                bus_error;
        logic                in_gap;
    } result_t;

    typedef struct packed {
        access_t             acc;
        result_t             want;
    } outcome_t;

    typedef struct {
        map_kind_e           kind;
        int unsigned         phys;
        bit                  fits;
    } placement_t;

    typedef struct {
        row_op_e             op;
        logic [CIDX_W-1:0]   reg_index;
        logic [SIZE_W-1:0]   reg_value;
        access_t             acc;
        check_e              check;
        result_t             want;
    } stim_row_t;

    localparam access_t NO_ACCESS  = '{REQ_BYTE_READ, '0, '0};
    localparam result_t R_NONE     = '{'0, 1'b0, 1'b0};
    localparam result_t R_WRITE    = '{'0, 1'b0, 1'b0};
    localparam result_t R_BUSERR   = '{'0, 1'b1, 1'b0};
    localparam result_t R_GAP_WR   = '{'0, 1'b0, 1'b1};
    localparam result_t R_GAP_BYTE = '{ONES_BYTE, 1'b0, 1'b1};
    localparam result_t R_GAP_WORD = '{ONES_WORD, 1'b0, 1'b1};
    localparam result_t R_OUT_BYTE = '{ONES_BYTE, 1'b0, 1'b0};

    // Bank setups for the random phases, extremes included.
    localparam t_cfg BANK_SETUPS [NUM_SETUPS] = '{
        '{SIZE_2M,   SIZE_2M,   SIZE_2M,   SIZE_2M,   1'b1},
        '{SIZE_2M,   SIZE_2M,   SIZE_128K, SIZE_512K, 1'b0},
        '{SIZE_512K, SIZE_2M,   SIZE_128K, SIZE_2M,   1'b1},
        '{SIZE_NONE, SIZE_2M,   SIZE_512K, SIZE_512K, 1'b0},
        '{SIZE_128K, SIZE_128K, SIZE_128K, SIZE_128K, 1'b0},
        '{SIZE_2M,   SIZE_512K, SIZE_512K, SIZE_NONE, 1'b1},
        '{SIZE_2M,   SIZE_2M,   SIZE_128K, SIZE_128K, 1'b1},
        '{SIZE_512K, SIZE_512K, SIZE_2M,   SIZE_2M,   1'b0},
        '{SIZE_NONE, SIZE_NONE, SIZE_NONE, SIZE_NONE, 1'b0}
    };

    // Directed table, starting from the reset setup (512KB banks, STF decoding).
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h000000, 16'hFFFF}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h000000, 16'h0000}, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_WRITE, 24'h000001, 16'h0000}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h000001, 16'h0000}, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h000000, 16'h0000}, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h000003, 16'h8001}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h000002, 16'h0000}, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h0FFFFE, 16'hA5A5}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h0FFFFF, 16'h0000}, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h100000, 16'h0000}, TYPED, R_GAP_BYTE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h3FFFFE, 16'h1234}, TYPED, R_GAP_WR},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h400000, 16'h0000}, TYPED, R_GAP_BYTE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h400001, 16'h0000}, TYPED, R_GAP_WORD},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h400001, 16'h0000}, TYPED, R_BUSERR},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'hFFFFFF, 16'h0000}, TYPED, R_BUSERR},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_WRITE, 24'h800000, 16'h00FF}, TYPED, R_BUSERR},
        '{ROW_CFG, CFG_BANK0_SIZE, SIZE_2M, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h000400, 16'h5A5A}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h000000, 16'h0000}, MODEL, R_NONE},
        '{ROW_CFG, CFG_MODEL_STE, 2'd1, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h080000, 16'h0000}, MODEL, R_NONE},
        '{ROW_CFG, CFG_REAL1_SIZE, SIZE_NONE, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h200000, 16'h0000}, TYPED, R_GAP_BYTE},
        '{ROW_CFG, CFG_MODEL_STE, 2'd0, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h0C0000, 16'h0000}, TYPED, R_OUT_BYTE},
        '{ROW_CFG, CFG_BANK0_SIZE, SIZE_NONE, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_READ,  24'h000000, 16'h0000}, TYPED, R_GAP_WORD},
        '{ROW_CFG, CFG_UNUSED_INDEX, SIZE_2M, NO_ACCESS, MODEL, R_NONE},
        '{ROW_CFG, CFG_REAL1_SIZE, SIZE_128K, NO_ACCESS, MODEL, R_NONE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_WORD_WRITE, 24'h000200, 16'h0F0F}, TYPED, R_WRITE},
        '{ROW_ACC, NO_REG, SIZE_NONE, '{REQ_BYTE_READ,  24'h040001, 16'h0000}, MODEL, R_NONE}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [SIZE_W-1:0]   cfg_wdata;

    mbrm_req_if req_ch ();
    mbrm_rsp_if rsp_ch ();

    // Predictor state: register copy, written words of the store, recent write addresses.
    t_cfg                shadow_cfg = '{SIZE_512K, SIZE_512K, SIZE_512K, SIZE_512K, 1'b0};
    bit [DATA_W-1:0]     ram_image [int unsigned];
    logic [ADDR_W-1:0]   touched_addrs [$];
    outcome_t            expected_results [$];

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  stall_cycles = 0;

    mismatched_bank_ram_mapper_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned bank_bytes(input logic [SIZE_W-1:0] code);
        case (code)
            SIZE_128K: return BYTES_128K;
            SIZE_512K: return BYTES_512K;
            SIZE_2M:   return BYTES_2M;
            default:   return 0;
        endcase
    endfunction

    // Splits a bus address into a bank, clears the lines the fitted chips lack and
    // relocates bank 1 above the fitted size of bank 0.
    function automatic placement_t place_access(input access_t acc);
        placement_t  pl;
        int unsigned ad, off, span, fitted, clr, real0, real1, need;
        bit          second, ste;
        ad     = 32'(acc.address);
        if (acc.kind[REQ_WORD_BIT])
            ad = ad & ~32'd1;
        real0  = bank_bytes(shadow_cfg.real_bank0_size);
        real1  = bank_bytes(shadow_cfg.real_bank1_size);
        ste    = shadow_cfg.model_is_ste;
        pl     = '{MAP_RAM, 0, 1'b0};
        clr    = 0;
        second = 1'b0;
        off    = ad;
        span   = bank_bytes(shadow_cfg.cfg_bank0_size);
        fitted = real0;
        if (ad > 32'(LIMIT_4MB)) begin
            pl.kind = MAP_BUS_ERROR;
            return pl;
        end
        if (off >= span) begin
            second = 1'b1;
            off    = off - span;
            span   = bank_bytes(shadow_cfg.cfg_bank1_size);
            fitted = real1;
        end
        if ((second && off >= span) || fitted == 0) begin
            pl.kind = MAP_GAP;
            return pl;
        end
        if (span == BYTES_2M && fitted == BYTES_512K)
            clr = ste ? CLR_2M_512K_STE : CLR_2M_512K_STF;
        else if (span == BYTES_2M && fitted == BYTES_128K)
            clr = ste ? CLR_2M_128K_STE : CLR_2M_128K_STF;
        else if (span == BYTES_512K && fitted == BYTES_128K)
            clr = ste ? CLR_512K_128K_STE : CLR_512K_128K_STF;
        pl.phys = (off & ~clr) + (second ? real0 : 0);
        need    = acc.kind[REQ_WORD_BIT] ? 2 : 1;
        pl.fits = (pl.phys + need <= real0 + real1) && ((pl.phys >> 1) < RAM_WORDS);
        return pl;
    endfunction

    // Works out the result of one transaction and applies its write to the store image.
    function automatic result_t resolve_access(input access_t acc);
        placement_t      pl;
        result_t         res;
        bit              is_word, is_write;
        int unsigned     idx;
        bit [DATA_W-1:0] w;
        pl       = place_access(acc);
        is_word  = acc.kind[REQ_WORD_BIT];
        is_write = acc.kind[REQ_WRITE_BIT];
        idx      = pl.phys >> 1;
        res      = R_NONE;
        case (pl.kind)
            MAP_BUS_ERROR: res.bus_error = 1'b1;
            MAP_GAP: begin
                res.in_gap = 1'b1;
                if (!is_write)
                    res.read_data = is_word ? ONES_WORD : ONES_BYTE;
            end
            default: begin
                w = ram_image.exists(idx) ? ram_image[idx] : '0;
                if (!is_write) begin
                    if (!pl.fits)
                        res.read_data = is_word ? ONES_WORD : ONES_BYTE;
                    else if (is_word)
                        res.read_data = w;
                    else
                        res.read_data = pl.phys[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
                end else if (pl.fits) begin
                    if (is_word)
                        w = acc.write_data;
                    else if (pl.phys[0])
                        w[7:0] = acc.write_data[7:0];
                    else
                        w[15:8] = acc.write_data[7:0];
                    ram_image[idx] = w;
                end
            end
        endcase
        return res;
    endfunction

    // True where the transaction, other than a word write, would use a store word that has never been written.
    function automatic bit touches_unwritten(input access_t acc);
        placement_t pl;
        pl = place_access(acc);
        return pl.kind == MAP_RAM && pl.fits && !ram_image.exists(pl.phys >> 1)
               && acc.kind != REQ_WORD_WRITE;
    endfunction

    function automatic void note_register_write(input logic [CIDX_W-1:0] index,
                                                input logic [SIZE_W-1:0] value);
        case (index)
            CFG_BANK0_SIZE: shadow_cfg.cfg_bank0_size  = value;
            CFG_BANK1_SIZE: shadow_cfg.cfg_bank1_size  = value;
            CFG_REAL0_SIZE: shadow_cfg.real_bank0_size = value;
            CFG_REAL1_SIZE: shadow_cfg.real_bank1_size = value;
            CFG_MODEL_STE:  shadow_cfg.model_is_ste    = value[0];
            default: ;
        endcase
    endfunction

    // Random transaction: mostly addresses near written data, bank edges and aliases,
    // with a share of wholly random addresses. Anything that would touch an unwritten
    // word becomes a word write, which fills it.
    function automatic access_t make_random_access();
        access_t     acc;
        int unsigned roll, base, cfg0, cfg1, real0, real1;
        cfg0  = bank_bytes(shadow_cfg.cfg_bank0_size);
        cfg1  = bank_bytes(shadow_cfg.cfg_bank1_size);
        real0 = bank_bytes(shadow_cfg.real_bank0_size);
        real1 = bank_bytes(shadow_cfg.real_bank1_size);
        acc.kind       = req_kind_e'($urandom_range(3));
        acc.write_data = DATA_W'($urandom_range(16'hFFFF));
        roll = (touched_addrs.size() == 0) ? $urandom_range(99, 50) : $urandom_range(99);
        if (roll < 40) begin
            acc.address = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
            acc.address[0] = acc.address[0] ^ 1'($urandom_range(1));
        end else if (roll < 50) begin
            acc.address = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
            acc.address = acc.address ^ (ADDR_W'(1) << ALIAS_BITS[$urandom_range(5)]);
        end else if (roll < 75) begin
            case ($urandom_range(6))
                0:       base = 0;
                1:       base = cfg0;
                2:       base = cfg0 + cfg1;
                3:       base = real0;
                4:       base = real0 + real1;
                5:       base = 32'(LIMIT_4MB);
                default: base = BYTES_2M;
            endcase
            acc.address = ADDR_W'(base + $urandom_range(1023) - 512);
        end else if (roll < 90) begin
            acc.address = ADDR_W'($urandom_range(32'(LIMIT_4MB) + 1));
        end else begin
            acc.address = ADDR_W'($urandom());
        end
        if (touches_unwritten(acc))
            acc.kind = REQ_WORD_WRITE;
        if (acc.kind[REQ_WRITE_BIT]) begin
            touched_addrs.push_back(acc.address);
            if (touched_addrs.size() > POOL_DEPTH)
                touched_addrs.delete($urandom_range(POOL_DEPTH - 1));
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Leaves the enable high; the next request transaction lowers it.
    task automatic write_register(input logic [CIDX_W-1:0] index,
                                  input logic [SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge i_clk);
        note_register_write(index, value);
    endtask

    // Presents one request, holds it until accepted and files its expected result.
    task automatic send_access(input access_t acc, input bit typed, input result_t typed_want);
        result_t predicted;
        if (cfg_we)
            cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= acc.kind;
        req_ch.address    <= acc.address;
        req_ch.write_data <= acc.write_data;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        predicted = resolve_access(acc);
        expected_results.push_back('{acc, typed ? typed_want : predicted});
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Response side: random back-pressure and in-order comparison.
    always @(posedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin : check_results
        outcome_t oldest;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                oldest = expected_results.pop_front();
                if (rsp_ch.read_data !== oldest.want.read_data)
                    report_mismatch($sformatf("result %0d (type %0d addr %h): read_data %h, want %h",
                        results_seen, oldest.acc.kind, oldest.acc.address,
                        rsp_ch.read_data, oldest.want.read_data));
                if (rsp_ch.bus_error !== oldest.want.bus_error)
                    report_mismatch($sformatf("result %0d (addr %h): bus_error %b, want %b",
                        results_seen, oldest.acc.address, rsp_ch.bus_error,
                        oldest.want.bus_error));
                if (rsp_ch.in_gap !== oldest.want.in_gap)
                    report_mismatch($sformatf("result %0d (addr %h): in_gap %b, want %b",
                        results_seen, oldest.acc.address, rsp_ch.in_gap,
                        oldest.want.in_gap));
            end
        end
    end

    // Watchdog: counts cycles in which no transaction and no register write happens.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases over the bank setups.
    initial begin : stimulus
        access_t acc;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_BANK0_SIZE;
        cfg_wdata         = SIZE_NONE;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_BYTE_READ;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                wait_for_results();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_access(directed_rows[i].acc, directed_rows[i].check == TYPED,
                            directed_rows[i].want);
            end
        end

        for (int s = 0; s < NUM_SETUPS; s++) begin
            wait_for_results();
            write_register(CFG_BANK0_SIZE, BANK_SETUPS[s].cfg_bank0_size);
            write_register(CFG_BANK1_SIZE, BANK_SETUPS[s].cfg_bank1_size);
            write_register(CFG_REAL0_SIZE, BANK_SETUPS[s].real_bank0_size);
            write_register(CFG_REAL1_SIZE, BANK_SETUPS[s].real_bank1_size);
            write_register(CFG_MODEL_STE,
                           {1'($urandom_range(1)), BANK_SETUPS[s].model_is_ste});
            // Receiver-heavy idling, then sender-heavy, then none at all.
            case (s / 3)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_SETUP) begin
                acc = make_random_access();
                send_access(acc, 1'b0, R_NONE);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
